/* src/dht_pkg.sv */
// Shared types and constants for the dual hysteresis thermostat.
`timescale 1ns / 1ps

package dht_pkg;

  localparam int unsigned TEMP_W = 16;
  localparam int unsigned TIME_W = 16;
  localparam int unsigned CFG_INDEX_W = 8;

  // Hold window for a stale sensor reading, in seconds
  localparam logic [TIME_W-1:0] STALE_HOLD_SECONDS = 16'd20;
  localparam logic signed [TEMP_W-1:0] SETPOINT_INVALID = 16'sh8000;

  typedef enum logic [2:0] {
    CODE_IDLE     = 3'd0,
    CODE_COOL     = 3'd1,
    CODE_COOL_MIN = 3'd2,
    CODE_HEAT     = 3'd3,
    CODE_HEAT_MIN = 3'd4,
    CODE_BOTH     = 3'd5
  } state_code_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_COOL_ON_OFFSET  = 8'd0,
    REG_COOL_OFF_OFFSET = 8'd1,
    REG_HEAT_ON_OFFSET  = 8'd2,
    REG_HEAT_OFF_OFFSET = 8'd3,
    REG_COOL_MIN_ON     = 8'd4,
    REG_COOL_MIN_OFF    = 8'd5,
    REG_HEAT_MIN_ON     = 8'd6,
    REG_HEAT_MIN_OFF    = 8'd7
  } cfg_reg_t;

  localparam logic signed [TEMP_W-1:0] RST_COOL_ON_OFFSET  = 16'sd768;
  localparam logic signed [TEMP_W-1:0] RST_COOL_OFF_OFFSET = -16'sd1024;
  localparam logic signed [TEMP_W-1:0] RST_HEAT_ON_OFFSET  = -16'sd102;
  localparam logic signed [TEMP_W-1:0] RST_HEAT_OFF_OFFSET = 16'sd102;
  localparam logic [TIME_W-1:0] RST_COOL_MIN_ON  = 16'd180;
  localparam logic [TIME_W-1:0] RST_COOL_MIN_OFF = 16'd5;
  localparam logic [TIME_W-1:0] RST_HEAT_MIN_ON  = 16'd5;
  localparam logic [TIME_W-1:0] RST_HEAT_MIN_OFF = 16'd3;

endpackage

/* src/dual_hysteresis_thermostat.sv */
// Dual hysteresis thermostat: two on/off loops with minimum on and off times.
//
// Usage:
//   s_* is the tick channel, one word per control tick: tdata carries the
//   time, both sensor readings and both setpoints, tuser the two sensor
//   freshness flags. m_* returns one result word per tick: the combined
//   state code and the cooler and heater drives.
//   cfg_* writes the eight band/timing registers, by index 0..7; other
//   indexes are dropped. cfg_ready is always high. Write only while idle.
// Path: an accepted tick passes the input register, then the loop update
//   feeding the result register.
// Throughput: one tick per cycle while the result is not stalled. The loop
//   state (drive bits, switch times, last good readings) is updated in the
//   same cycle the result register loads, so the next tick sees it.
// Reset (rst, synchronous): both drives off, switch times and good-reading
//   stores zeroed, good readings marked invalid, registers to their
//   defaults, both word registers empty.
// Stall: a held result keeps its value; the input register still takes a
//   new word, and s_tready drops only when both stages are full and m_tready
//   is low.
`timescale 1ns / 1ps

module dual_hysteresis_thermostat
  import dht_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // tick channel
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // [15:0] now_seconds, [31:16] chamber_temp, [47:32] product_temp,
  // [63:48] cool_setpoint, [79:64] heat_setpoint
  input  logic [79:0]            s_tdata,
  // [0] chamber_present, [1] product_present
  input  logic [1:0]             s_tuser,
  // result channel
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [2:0] state_code, [3] cooler_on, [4] heater_on, [7:5] zero
  output logic [7:0]             m_tdata,
  // configuration write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]            cfg_data
);

  // ---------------- configuration registers ----------------
  logic signed [TEMP_W-1:0] cool_on_offset, cool_off_offset;
  logic signed [TEMP_W-1:0] heat_on_offset, heat_off_offset;
  logic [TIME_W-1:0] cool_min_on, cool_min_off;
  logic [TIME_W-1:0] heat_min_on, heat_min_off;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cool_on_offset  <= RST_COOL_ON_OFFSET;
      cool_off_offset <= RST_COOL_OFF_OFFSET;
      heat_on_offset  <= RST_HEAT_ON_OFFSET;
      heat_off_offset <= RST_HEAT_OFF_OFFSET;
      cool_min_on     <= RST_COOL_MIN_ON;
      cool_min_off    <= RST_COOL_MIN_OFF;
      heat_min_on     <= RST_HEAT_MIN_ON;
      heat_min_off    <= RST_HEAT_MIN_OFF;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COOL_ON_OFFSET:  cool_on_offset  <= cfg_data;
        REG_COOL_OFF_OFFSET: cool_off_offset <= cfg_data;
        REG_HEAT_ON_OFFSET:  heat_on_offset  <= cfg_data;
        REG_HEAT_OFF_OFFSET: heat_off_offset <= cfg_data;
        REG_COOL_MIN_ON:     cool_min_on     <= cfg_data;
        REG_COOL_MIN_OFF:    cool_min_off    <= cfg_data;
        REG_HEAT_MIN_ON:     heat_min_on     <= cfg_data;
        REG_HEAT_MIN_OFF:    heat_min_off    <= cfg_data;
        default: ;  // unknown index: dropped
      endcase
    end
  end

  // ---------------- input register ----------------
  logic        in_valid;
  logic [79:0] in_data;
  logic [1:0]  in_user;
  logic        advance;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_data <= s_tdata;
      in_user <= s_tuser;
    end
  end

  // ---------------- loop state ----------------
  logic                     cooler, heater;
  logic [TIME_W-1:0]        cool_switch_time, heat_switch_time;
  logic [TIME_W-1:0]        chamber_good_time, product_good_time;
  logic signed [TEMP_W-1:0] chamber_good_temp, product_good_temp;
  logic                     chamber_good_valid, product_good_valid;

  // ---------------- update logic ----------------
  logic [TIME_W-1:0]        now;
  logic signed [TEMP_W-1:0] ch_raw, pr_raw, csp, hsp, ch, pr;
  logic                     ch_present, pr_present, ch_ok, pr_ok;
  logic [TIME_W-1:0]        since_cool, since_heat;
  logic signed [TEMP_W:0]   ch_x, pr_x, cool_on_lvl, cool_off_lvl, heat_on_lvl, heat_off_lvl;
  logic                     cool_en, heat_en, cool_want, cool_sat, heat_want, heat_sat;
  logic                     cooler_next, heater_next, cool_sw, heat_sw;
  state_code_t              code_next;

  assign now        = in_data[15:0];
  assign ch_raw     = in_data[31:16];
  assign pr_raw     = in_data[47:32];
  assign csp        = in_data[63:48];
  assign hsp        = in_data[79:64];
  assign ch_present = in_user[0];
  assign pr_present = in_user[1];

  assign since_cool = now - cool_switch_time;
  assign since_heat = now - heat_switch_time;

  // fresh reading, else the last good one inside the hold window
  assign ch_ok = ch_present ||
                 (chamber_good_valid && (now - chamber_good_time) <= STALE_HOLD_SECONDS);
  assign pr_ok = pr_present ||
                 (product_good_valid && (now - product_good_time) <= STALE_HOLD_SECONDS);
  assign ch = ch_present ? ch_raw : chamber_good_temp;
  assign pr = pr_present ? pr_raw : product_good_temp;

  // band edges at 17 bits, no wrap
  assign ch_x         = {ch[TEMP_W-1], ch};
  assign pr_x         = {pr[TEMP_W-1], pr};
  assign cool_on_lvl  = {csp[TEMP_W-1], csp} + {cool_on_offset[TEMP_W-1], cool_on_offset};
  assign cool_off_lvl = {csp[TEMP_W-1], csp} + {cool_off_offset[TEMP_W-1], cool_off_offset};
  assign heat_on_lvl  = {hsp[TEMP_W-1], hsp} + {heat_on_offset[TEMP_W-1], heat_on_offset};
  assign heat_off_lvl = {hsp[TEMP_W-1], hsp} + {heat_off_offset[TEMP_W-1], heat_off_offset};

  assign cool_en   = ch_ok && (csp != SETPOINT_INVALID);
  assign heat_en   = pr_ok && (hsp != SETPOINT_INVALID);
  assign cool_want = cool_en && (ch_x > cool_on_lvl);
  assign cool_sat  = cool_en && (ch_x <= cool_off_lvl);
  assign heat_want = heat_en && (pr_x < heat_on_lvl);
  assign heat_sat  = heat_en && (pr_x >= heat_off_lvl);

  // an unknown sensor drops the drive at once, ignoring minimum on time
  always_comb begin
    if (cooler) begin
      cool_sw = !ch_ok || (cool_sat && (since_cool > cool_min_on));
    end else begin
      cool_sw = cool_want && (since_cool > cool_min_off);
    end
    if (heater) begin
      heat_sw = !pr_ok || (heat_sat && (since_heat > heat_min_on));
    end else begin
      heat_sw = heat_want && (since_heat > heat_min_off);
    end
    cooler_next = cooler ^ cool_sw;
    heater_next = heater ^ heat_sw;

    if (cooler_next && heater_next) begin
      code_next = CODE_BOTH;
    end else if (cooler_next) begin
      code_next = (cool_sat && (since_cool <= cool_min_on)) ? CODE_COOL_MIN : CODE_COOL;
    end else if (heater_next) begin
      code_next = (heat_sat && (since_heat <= heat_min_on)) ? CODE_HEAT_MIN : CODE_HEAT;
    end else begin
      code_next = CODE_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cooler             <= 1'b0;
      heater             <= 1'b0;
      cool_switch_time   <= '0;
      heat_switch_time   <= '0;
      chamber_good_time  <= '0;
      product_good_time  <= '0;
      chamber_good_temp  <= '0;
      product_good_temp  <= '0;
      chamber_good_valid <= 1'b0;
      product_good_valid <= 1'b0;
    end else if (advance) begin
      cooler <= cooler_next;
      heater <= heater_next;
      if (cool_sw) begin
        cool_switch_time <= now;
      end
      if (heat_sw) begin
        heat_switch_time <= now;
      end
      if (ch_present) begin
        chamber_good_time  <= now;
        chamber_good_temp  <= ch_raw;
        chamber_good_valid <= 1'b1;
      end
      if (pr_present) begin
        product_good_time  <= now;
        product_good_temp  <= pr_raw;
        product_good_valid <= 1'b1;
      end
    end
  end

  // ---------------- result register ----------------
  state_code_t out_code;
  logic        out_cooler, out_heater;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_code   <= code_next;
      out_cooler <= cooler_next;
      out_heater <= heater_next;
    end
  end

  assign m_tdata = {3'b000, out_heater, out_cooler, out_code};

endmodule

/* src/dht_checker.sv */
// Port-level checks for the thermostat, bound to the top level.
`timescale 1ns / 1ps

module dht_checker
  import dht_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  logic is_cool_code, is_heat_code;
  assign is_cool_code = (m_tdata[2:0] == CODE_COOL) || (m_tdata[2:0] == CODE_COOL_MIN) ||
                        (m_tdata[2:0] == CODE_BOTH);
  assign is_heat_code = (m_tdata[2:0] == CODE_HEAT) || (m_tdata[2:0] == CODE_HEAT_MIN) ||
                        (m_tdata[2:0] == CODE_BOTH);

  // a held result word does not change
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // nothing comes out right after reset
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // cooler drive agrees with the state code
  a_cool_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[3] == is_cool_code))
    else $error("cooler drive and state code disagree");

  // heater drive agrees with the state code
  a_heat_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[4] == is_heat_code))
    else $error("heater drive and state code disagree");

  // padding bits stay zero
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:5] == 3'b000))
    else $error("result padding not zero");

endmodule

bind dual_hysteresis_thermostat dht_checker u_dht_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

/* test/tb_dual_hysteresis_thermostat.sv */
// Self-checking testbench for the dual hysteresis thermostat: tick stream in, drive words out.
`timescale 1ns / 1ps

import dht_pkg::*;

// One control tick as the block sees it
typedef struct {
  logic [TIME_W-1:0]        now;
  logic signed [TEMP_W-1:0] chamber;
  bit                       chamber_fresh;
  logic signed [TEMP_W-1:0] product;
  bit                       product_fresh;
  logic signed [TEMP_W-1:0] cool_sp;
  logic signed [TEMP_W-1:0] heat_sp;
} tick_t;

// One result word, unpacked
typedef struct {
  state_code_t code;
  bit          cooler;
  bit          heater;
} drive_t;

// Predicts the drive word for every accepted tick and checks the words that come back.
class drive_board;
  logic signed [TEMP_W-1:0] cool_on_ofs, cool_off_ofs, heat_on_ofs, heat_off_ofs;
  logic [TIME_W-1:0]        min_cool_on, min_cool_off, min_heat_on, min_heat_off;

  state_code_t              mode;
  logic [TIME_W-1:0]        cool_switch_at, heat_switch_at;
  logic [TIME_W-1:0]        chamber_seen_at, product_seen_at;
  logic signed [TEMP_W-1:0] chamber_last, product_last;
  bit                       chamber_seen, product_seen;

  drive_t expected_drives[$];
  int     errors;

  function new();
    cool_on_ofs     = RST_COOL_ON_OFFSET;
    cool_off_ofs    = RST_COOL_OFF_OFFSET;
    heat_on_ofs     = RST_HEAT_ON_OFFSET;
    heat_off_ofs    = RST_HEAT_OFF_OFFSET;
    min_cool_on     = RST_COOL_MIN_ON;
    min_cool_off    = RST_COOL_MIN_OFF;
    min_heat_on     = RST_HEAT_MIN_ON;
    min_heat_off    = RST_HEAT_MIN_OFF;
    mode            = CODE_IDLE;
    cool_switch_at  = '0;
    heat_switch_at  = '0;
    chamber_seen_at = '0;
    product_seen_at = '0;
    chamber_last    = '0;
    product_last    = '0;
    chamber_seen    = 1'b0;
    product_seen    = 1'b0;
    errors          = 0;
  endfunction

  function int pending();
    return expected_drives.size();
  endfunction

  function void set_reg(logic [CFG_INDEX_W-1:0] index, logic [15:0] value);
    case (index)
      REG_COOL_ON_OFFSET:  cool_on_ofs  = value;
      REG_COOL_OFF_OFFSET: cool_off_ofs = value;
      REG_HEAT_ON_OFFSET:  heat_on_ofs  = value;
      REG_HEAT_OFF_OFFSET: heat_off_ofs = value;
      REG_COOL_MIN_ON:     min_cool_on  = value;
      REG_COOL_MIN_OFF:    min_cool_off = value;
      REG_HEAT_MIN_ON:     min_heat_on  = value;
      REG_HEAT_MIN_OFF:    min_heat_off = value;
      default: ;
    endcase
  endfunction

  // Fresh reading is stored; a stale one is covered by the stored value for a while.
  function bit hold_reading(input logic [TIME_W-1:0] now, input logic signed [TEMP_W-1:0] raw,
                            input bit fresh, inout logic [TIME_W-1:0] seen_at,
                            inout logic signed [TEMP_W-1:0] last, inout bit seen,
                            output logic signed [TEMP_W-1:0] held);
    logic [TIME_W-1:0] age;
    age  = now - seen_at;
    held = raw;
    if (fresh) begin
      seen_at = now;
      last    = raw;
      seen    = 1'b1;
      return 1'b1;
    end
    if (seen && age <= STALE_HOLD_SECONDS) begin
      held = last;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function void note_tick(tick_t t);
    logic [TIME_W-1:0]        since_cool, since_heat;
    logic signed [TEMP_W-1:0] ch, pr;
    bit ch_ok, pr_ok, cool_en, heat_en, cool_want, cool_sat, heat_want, heat_sat;
    bit cool_run, heat_run;
    drive_t d;

    since_cool = t.now - cool_switch_at;
    since_heat = t.now - heat_switch_at;
    ch_ok = hold_reading(t.now, t.chamber, t.chamber_fresh, chamber_seen_at, chamber_last,
                         chamber_seen, ch);
    pr_ok = hold_reading(t.now, t.product, t.product_fresh, product_seen_at, product_last,
                         product_seen, pr);

    // band edges compared at full int width, no wrap
    cool_en   = ch_ok && (t.cool_sp != SETPOINT_INVALID);
    heat_en   = pr_ok && (t.heat_sp != SETPOINT_INVALID);
    cool_want = cool_en && (int'(ch) >  int'(t.cool_sp) + int'(cool_on_ofs));
    cool_sat  = cool_en && (int'(ch) <= int'(t.cool_sp) + int'(cool_off_ofs));
    heat_want = heat_en && (int'(pr) <  int'(t.heat_sp) + int'(heat_on_ofs));
    heat_sat  = heat_en && (int'(pr) >= int'(t.heat_sp) + int'(heat_off_ofs));

    cool_run = mode inside {CODE_COOL, CODE_COOL_MIN, CODE_BOTH};
    heat_run = mode inside {CODE_HEAT, CODE_HEAT_MIN, CODE_BOTH};

    // lost sensor drops the loop at once, ignoring its minimum on time
    if (cool_run) begin
      if ((cool_sat || !ch_ok) && (since_cool > min_cool_on || !ch_ok)) begin
        cool_switch_at = t.now;
        cool_run       = 1'b0;
      end
    end else if (cool_want && since_cool > min_cool_off) begin
      cool_switch_at = t.now;
      cool_run       = 1'b1;
    end

    if (heat_run) begin
      if ((heat_sat || !pr_ok) && (since_heat > min_heat_on || !pr_ok)) begin
        heat_switch_at = t.now;
        heat_run       = 1'b0;
      end
    end else if (heat_want && since_heat > min_heat_off) begin
      heat_switch_at = t.now;
      heat_run       = 1'b1;
    end

    if (cool_run && heat_run) begin
      mode = CODE_BOTH;
    end else if (cool_run) begin
      if (cool_sat && since_cool <= min_cool_on) mode = CODE_COOL_MIN;
      else mode = CODE_COOL;
    end else if (heat_run) begin
      if (heat_sat && since_heat <= min_heat_on) mode = CODE_HEAT_MIN;
      else mode = CODE_HEAT;
    end else begin
      mode = CODE_IDLE;
    end

    d.code   = mode;
    d.cooler = cool_run;
    d.heater = heat_run;
    expected_drives.push_back(d);
  endfunction

  function void check_result(logic [7:0] word);
    drive_t want;
    if (expected_drives.size() == 0) begin
      $display("%0t: drive word %h arrived with no tick outstanding", $time, word);
      errors++;
      return;
    end
    want = expected_drives.pop_front();
    if (word[2:0] !== want.code) begin
      $display("%0t: state_code expected %0d, got %0d", $time, want.code, word[2:0]);
      errors++;
    end
    if (word[3] !== want.cooler) begin
      $display("%0t: cooler_on expected %0b, got %0b", $time, want.cooler, word[3]);
      errors++;
    end
    if (word[4] !== want.heater) begin
      $display("%0t: heater_on expected %0b, got %0b", $time, want.heater, word[4]);
      errors++;
    end
    if (word[7:5] !== 3'b000) begin
      $display("%0t: pad bits expected 0, got %b", $time, word[7:5]);
      errors++;
    end
  endfunction
endclass

module tb_dual_hysteresis_thermostat;

  localparam int RANDOM_TICKS = 850;
  // indexes past the register list; writes there must be dropped
  localparam logic [CFG_INDEX_W-1:0] REG_PAST_LIST = 8'd8;
  localparam logic [CFG_INDEX_W-1:0] REG_INDEX_TOP = 8'hFF;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [79:0]            s_tdata = '0;
  logic [1:0]             s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [7:0]             m_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [15:0]            cfg_data = '0;

  drive_board board;

  // Plant: time base, sensor levels drifting around the setpoints, dropout counters
  logic [TIME_W-1:0]        clock_now;
  int                       chamber_level, product_level;
  int                       chamber_gap, product_gap;
  logic signed [TEMP_W-1:0] cool_target, heat_target;

  dual_hysteresis_thermostat uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop; normal runs finish in a small fraction of this
  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

  // Every accepted result word goes to the board
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata);
  end

  // Receiver: spans of always-ready, coin-flip stalls, and long stalls
  initial begin
    int pattern;
    int span;
    forever begin
      pattern = $urandom_range(0, 2);
      span    = $urandom_range(20, 150);
      repeat (span) begin
        @(posedge clk);
        case (pattern)
          0:       m_tready <= 1'b1;
          1:       m_tready <= 1'($urandom_range(0, 1));
          default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // Drive one tick word and hold it until taken; valid stays high for the caller
  task automatic put_tick(input tick_t t);
    s_tvalid <= 1'b1;
    s_tdata  <= {t.heat_sp, t.cool_sp, t.product, t.chamber, t.now};
    s_tuser  <= {t.product_fresh, t.chamber_fresh};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_tick(t);
  endtask

  task automatic put_reg(input logic [CFG_INDEX_W-1:0] index, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_reg(index, value);
  endtask

  // Full register set, optionally followed by a write past the list
  task automatic apply_config(input logic [15:0] c_on, input logic [15:0] c_off,
                              input logic [15:0] h_on, input logic [15:0] h_off,
                              input logic [15:0] c_on_t, input logic [15:0] c_off_t,
                              input logic [15:0] h_on_t, input logic [15:0] h_off_t,
                              input bit poke_unused);
    put_reg(REG_COOL_ON_OFFSET, c_on);
    put_reg(REG_COOL_OFF_OFFSET, c_off);
    put_reg(REG_HEAT_ON_OFFSET, h_on);
    put_reg(REG_HEAT_OFF_OFFSET, h_off);
    put_reg(REG_COOL_MIN_ON, c_on_t);
    put_reg(REG_COOL_MIN_OFF, c_off_t);
    put_reg(REG_HEAT_MIN_ON, h_on_t);
    put_reg(REG_HEAT_MIN_OFF, h_off_t);
    if (poke_unused)
      put_reg($urandom_range(0, 1) ? REG_PAST_LIST : REG_INDEX_TOP, 16'($urandom));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stop sending and wait out every outstanding result, plus the pipeline depth
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic tick_t mk(input logic [15:0] now, input logic [15:0] ch, input bit chf,
                               input logic [15:0] pr, input bit prf,
                               input logic [15:0] csp, input logic [15:0] hsp);
    tick_t t;
    t.now           = now;
    t.chamber       = ch;
    t.chamber_fresh = chf;
    t.product       = pr;
    t.product_fresh = prf;
    t.cool_sp       = csp;
    t.heat_sp       = hsp;
    return t;
  endfunction

  function automatic logic [15:0] pick_offset();
    case ($urandom_range(0, 11))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      default: return 16'($urandom_range(0, 4000) - 2000);
    endcase
  endfunction

  function automatic logic [15:0] pick_hold();
    case ($urandom_range(0, 11))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 30));
    endcase
  endfunction

  function automatic logic signed [15:0] pick_setpoint();
    case ($urandom_range(0, 15))
      0, 1:    return SETPOINT_INVALID;
      2:       return 16'sh7FFF;
      3:       return -16'sd32767;
      default: return 16'($urandom_range(0, 16000) - 8000);
    endcase
  endfunction

  function automatic int clamp16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Next plant tick: mostly well-formed drift with dropouts, some pure noise
  function automatic tick_t make_tick();
    tick_t t;
    int    step_sel;
    int    cool_base, heat_base;
    if ($urandom_range(0, 9) == 0) begin
      t = mk(16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)), 16'($urandom),
             1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom));
      return t;
    end
    step_sel = $urandom_range(0, 19);
    if (step_sel < 13) clock_now += 16'd1;
    else if (step_sel < 15) clock_now = clock_now;
    else if (step_sel < 18) clock_now += 16'($urandom_range(2, 6));
    else if (step_sel == 18) clock_now += 16'($urandom_range(15, 40));
    else clock_now = 16'($urandom);

    if ($urandom_range(0, 49) == 0) cool_target = pick_setpoint();
    if ($urandom_range(0, 49) == 0) heat_target = pick_setpoint();
    cool_base = (cool_target == SETPOINT_INVALID) ? 0 : int'(cool_target);
    heat_base = (heat_target == SETPOINT_INVALID) ? 0 : int'(heat_target);

    if ($urandom_range(0, 11) == 0)
      chamber_level = clamp16(cool_base + int'($urandom_range(0, 6000)) - 3000);
    else
      chamber_level = clamp16(chamber_level + int'($urandom_range(0, 300)) - 150);
    if ($urandom_range(0, 11) == 0)
      product_level = clamp16(heat_base + int'($urandom_range(0, 6000)) - 3000);
    else
      product_level = clamp16(product_level + int'($urandom_range(0, 300)) - 150);

    // dropouts both shorter and longer than the hold window
    if (chamber_gap == 0 && $urandom_range(0, 39) == 0) chamber_gap = $urandom_range(1, 35);
    if (product_gap == 0 && $urandom_range(0, 39) == 0) product_gap = $urandom_range(1, 35);

    t.now           = clock_now;
    t.chamber_fresh = (chamber_gap == 0);
    t.product_fresh = (product_gap == 0);
    t.chamber       = t.chamber_fresh ? 16'(chamber_level) : 16'($urandom);
    t.product       = t.product_fresh ? 16'(product_level) : 16'($urandom);
    t.cool_sp       = cool_target;
    t.heat_sp       = heat_target;
    if (chamber_gap != 0) chamber_gap--;
    if (product_gap != 0) product_gap--;
    return t;
  endfunction

  initial begin
    int sent;
    int phase;
    int plen;
    int burst;
    bit gappy;

    board = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, reset register values.
    // Start after reset: minimum off times count from time 0.
    put_tick(mk(16'd0, 16'd0, 1'b1, 16'd0, 1'b1, SETPOINT_INVALID, SETPOINT_INVALID));
    put_tick(mk(16'd3, 16'sh7FFF, 1'b1, 16'sh8000, 1'b1, 16'd0, 16'd0));
    // both loops start together
    put_tick(mk(16'd6, 16'sh7FFF, 1'b1, 16'sh8000, 1'b1, 16'd0, 16'd0));
    // both satisfied but held by minimum on times
    put_tick(mk(16'd8, -16'sd2000, 1'b1, 16'd1000, 1'b1, 16'd0, 16'd0));
    // product stale, held value still satisfies heating; cool held at min time
    put_tick(mk(16'd12, -16'sd2000, 1'b1, 16'hA5A5, 1'b0, 16'd0, 16'd0));
    // stale product exactly at the edge of the hold window, then just past it
    put_tick(mk(16'd28, -16'sd2000, 1'b1, 16'h5A5A, 1'b0, 16'd0, 16'd0));
    put_tick(mk(16'd29, -16'sd2000, 1'b1, 16'h5A5A, 1'b0, 16'd0, 16'd0));
    // chamber stale but held, then unknown: cooling drops despite min on time
    put_tick(mk(16'd30, 16'hFFFF, 1'b0, 16'd0, 1'b1, 16'd0, 16'd0));
    put_tick(mk(16'd51, 16'hFFFF, 1'b0, 16'd0, 1'b1, 16'd0, 16'd0));
    // cool setpoint invalid: only heating runs
    put_tick(mk(16'd60, 16'sh7FFF, 1'b1, 16'sh8000, 1'b1, SETPOINT_INVALID, 16'd0));
    put_tick(mk(16'd62, 16'sh7FFF, 1'b1, 16'd200, 1'b1, SETPOINT_INVALID, 16'd0));
    // heat setpoint goes invalid while heating: stays on until the sensor is lost
    put_tick(mk(16'd63, 16'd0, 1'b1, 16'sh8000, 1'b1, SETPOINT_INVALID, SETPOINT_INVALID));
    put_tick(mk(16'd70, 16'd0, 1'b1, 16'sh7FFF, 1'b1, SETPOINT_INVALID, SETPOINT_INVALID));
    put_tick(mk(16'd100, 16'd0, 1'b1, 16'd0, 1'b0, SETPOINT_INVALID, SETPOINT_INVALID));
    // time at its top, then wrapping through zero
    put_tick(mk(16'hFFFF, 16'sh7FFF, 1'b1, 16'sh7FFF, 1'b1, -16'sd32767, 16'sh7FFF));
    put_tick(mk(16'd0, 16'sh8000, 1'b1, 16'sh7FFF, 1'b1, 16'sh7FFF, 16'sh7FFF));
    put_tick(mk(16'd200, 16'sh8000, 1'b1, 16'sh8000, 1'b1, 16'sh7FFF, -16'sd32767));
    put_tick(mk(16'd204, 16'sh8000, 1'b1, 16'sh8000, 1'b1, 16'sh7FFF, -16'sd32767));
    drain();

    // Random part: one register setting per phase, plant-driven ticks within it
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_TICKS) begin
      case (phase)
        0:       apply_config(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                              16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
        1:       apply_config(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                              16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        2:       apply_config(RST_COOL_ON_OFFSET, RST_COOL_OFF_OFFSET,
                              RST_HEAT_ON_OFFSET, RST_HEAT_OFF_OFFSET,
                              16'd8, RST_COOL_MIN_OFF,
                              RST_HEAT_MIN_ON, RST_HEAT_MIN_OFF, 1'b0);
        default: apply_config(pick_offset(), pick_offset(), pick_offset(), pick_offset(),
                              pick_hold(), pick_hold(), pick_hold(), pick_hold(),
                              $urandom_range(0, 2) == 0);
      endcase

      clock_now     = 16'($urandom);
      cool_target   = pick_setpoint();
      heat_target   = pick_setpoint();
      chamber_level = (cool_target == SETPOINT_INVALID) ? 0 : int'(cool_target);
      product_level = (heat_target == SETPOINT_INVALID) ? 0 : int'(heat_target);
      chamber_gap   = 0;
      product_gap   = 0;

      plen  = $urandom_range(30, 90);
      gappy = ($urandom_range(0, 3) != 0);
      burst = $urandom_range(1, 20);
      for (int k = 0; k < plen; k++) begin
        put_tick(make_tick());
        sent++;
        burst--;
        if ($urandom_range(0, 199) == 0) begin
          // hold the sender until everything outstanding is back
          drain();
        end else if (gappy && burst <= 0) begin
          s_tvalid <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
          burst = $urandom_range(1, 20);
        end
      end
      drain();
      phase++;
    end

    repeat (10) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
